[hdl/i2cbm_pkg.sv]
package i2cbm_pkg;

  // command codes carried in the opcode field
  typedef enum logic [2:0] {
    OP_START    = 3'd0,
    OP_STOP     = 3'd1,
    OP_WAIT_ACK = 3'd2,
    OP_WRITE    = 3'd3,
    OP_READ     = 3'd4,
    OP_ACK      = 3'd5,
    OP_NACK     = 3'd6
  } opcode_t;

  localparam int unsigned BITS_PER_BYTE = 8;

  // configuration register indexes and reset values
  localparam logic REG_SLOT_TICKS     = 1'b0;
  localparam logic REG_ACK_POLL_LIMIT = 1'b1;
  localparam logic [15:0] SLOT_TICKS_RST     = 16'd20;
  localparam logic [15:0] ACK_POLL_LIMIT_RST = 16'd60000;

  // one bus tick offered to the block
  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] opcode;
    logic [7:0] write_data;
    logic       sda_in;
  } tick_t;

  // line drives and status for one tick
  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_seen;
    logic       ack_timeout;
  } result_t;

  // classified tick as held in the queue
  typedef struct packed {
    logic       cmd_go;
    opcode_t    op;
    logic [7:0] wdata;
    logic       sda;
  } entry_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic nonempty;
  } q_status_t;

endpackage

[hdl/i2cbm_front.sv]
module i2cbm_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               tick_valid,
  output logic               tick_stall,
  input  i2cbm_pkg::tick_t   tick,
  input  i2cbm_pkg::q_status_t q_status,
  output logic               push,
  output i2cbm_pkg::entry_t  push_entry
);
  import i2cbm_pkg::*;

  logic seen_reset;

  // hold off requests in the cycle right after reset and whenever the queue is full
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_reset <= 1'b1;
    end else begin
      seen_reset <= 1'b0;
    end
  end

  assign tick_stall = q_status.full | seen_reset;
  assign push       = tick_valid & ~tick_stall;

  // classify: a command only counts when offered with a known opcode
  always_comb begin
    push_entry.cmd_go = tick.cmd_valid & (tick.opcode <= 3'(OP_NACK));
    push_entry.op     = opcode_t'(tick.opcode);
    push_entry.wdata  = tick.write_data;
    push_entry.sda    = tick.sda_in;
  end

endmodule

[hdl/i2cbm_queue.sv]
module i2cbm_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  i2cbm_pkg::entry_t    push_entry,
  input  logic                 pop,
  output i2cbm_pkg::entry_t    head,
  output i2cbm_pkg::q_status_t status
);
  import i2cbm_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  entry_t             entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign head            = entries[rd_ptr];
  assign status.full     = (count == CNT_W'(DEPTH));
  assign status.nonempty = (count != '0);

endmodule

[hdl/i2cbm_back.sv]
module i2cbm_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [15:0]          slot_ticks,
  input  logic [15:0]          ack_poll_limit,
  input  i2cbm_pkg::q_status_t q_status,
  input  i2cbm_pkg::entry_t    head,
  output logic                 pop,
  output logic                 res_valid,
  input  logic                 res_stall,
  output i2cbm_pkg::result_t   res
);
  import i2cbm_pkg::*;

  typedef struct packed {
    logic scl;
    logic sda;
    logic poll_clr;
  } slot_lv_t;

  // levels set on entry to a slot
  function automatic slot_lv_t enter_slot(opcode_t cmd, logic [4:0] idx, logic [1:0] ph,
                                          logic msb, logic scl, logic sda);
    slot_lv_t r;
    r.scl      = scl;
    r.sda      = sda;
    r.poll_clr = 1'b0;
    case (cmd)
      OP_START: begin
        r.scl = 1'b1;
        r.sda = (idx == 5'd0);
      end
      OP_STOP: begin
        if (idx == 5'd0) r.scl = 1'b0;
        else if (idx == 5'd1) r.sda = 1'b0;
        else if (idx == 5'd2) r.scl = 1'b1;
        else r.sda = 1'b1;
      end
      OP_WAIT_ACK: begin
        if (idx == 5'd0) begin
          r.scl = 1'b0;
          r.sda = 1'b1;
        end else if (idx == 5'd1) begin
          r.scl      = 1'b1;
          r.poll_clr = 1'b1;
        end else if (idx == 5'd3) begin
          r.scl = 1'b0;
        end
      end
      OP_WRITE: begin
        if (idx >= 5'(3 * BITS_PER_BYTE)) r.scl = 1'b0;
        else if (ph == 2'd0) r.scl = 1'b0;
        else if (ph == 2'd1) r.sda = msb;
        else r.scl = 1'b1;
      end
      OP_READ: begin
        r.sda = 1'b1;
        r.scl = idx[0];
      end
      default: begin
        if (idx == 5'd0) r.scl = 1'b0;
        else if (idx == 5'd1) r.sda = (cmd == OP_NACK);
        else if (idx == 5'd2) r.scl = 1'b1;
        else r.scl = 1'b0;
      end
    endcase
    return r;
  endfunction

  // number of slots in each command
  function automatic logic [4:0] slot_count(opcode_t cmd);
    case (cmd)
      OP_START: return 5'd3;
      OP_WRITE: return 5'(3 * BITS_PER_BYTE + 1);
      OP_READ:  return 5'(2 * BITS_PER_BYTE);
      default:  return 5'd4;
    endcase
  endfunction

  // sequencer registers
  logic        scl_level, sda_level, running;
  opcode_t     active_cmd;
  logic [4:0]  slot_index;
  logic [1:0]  bit_phase;
  logic [15:0] slot_counter, poll_counter;
  logic [7:0]  shift_reg, rd_byte;
  logic        ack_seen_r, ack_timeout_r;

  logic        scl_level_next, sda_level_next, running_next;
  opcode_t     active_cmd_next;
  logic [4:0]  slot_index_next;
  logic [1:0]  bit_phase_next;
  logic [15:0] slot_counter_next, poll_counter_next;
  logic [7:0]  shift_reg_next, rd_byte_next;
  logic        ack_seen_next, ack_timeout_next;

  result_t     res_calc;
  logic [15:0] slot_len;
  logic        advance;
  slot_lv_t    lv;

  // take the next tick when the output register is free or being drained
  assign pop      = q_status.nonempty & (~res_valid | ~res_stall);
  assign slot_len = (slot_ticks == 16'd0) ? 16'd1 : slot_ticks;

  // one tick of the bus sequencer
  always_comb begin
    scl_level_next    = scl_level;
    sda_level_next    = sda_level;
    running_next      = running;
    active_cmd_next   = active_cmd;
    slot_index_next   = slot_index;
    bit_phase_next    = bit_phase;
    slot_counter_next = slot_counter;
    poll_counter_next = poll_counter;
    shift_reg_next    = shift_reg;
    rd_byte_next      = rd_byte;
    ack_seen_next     = ack_seen_r;
    ack_timeout_next  = ack_timeout_r;
    advance           = 1'b0;
    lv                = '0;
    res_calc          = '0;

    if (pop) begin
      // start a new command when idle
      if (!running && head.cmd_go) begin
        running_next      = 1'b1;
        active_cmd_next   = head.op;
        slot_index_next   = 5'd0;
        bit_phase_next    = 2'd0;
        slot_counter_next = 16'd0;
        poll_counter_next = 16'd0;
        shift_reg_next    = (head.op == OP_WRITE) ? head.wdata : 8'd0;
        lv = enter_slot(active_cmd_next, 5'd0, 2'd0, shift_reg_next[7],
                        scl_level_next, sda_level_next);
        scl_level_next = lv.scl;
        sda_level_next = lv.sda;
      end
      res_calc.scl_out = scl_level_next;
      res_calc.sda_out = sda_level_next;

      if (running_next) begin
        res_calc.busy_res = 1'b1;
        if (active_cmd_next == OP_WAIT_ACK && slot_index_next == 5'd1) begin
          // poll phase
          if (!head.sda) begin
            ack_seen_next    = 1'b1;
            ack_timeout_next = 1'b0;
            advance          = 1'b1;
          end else begin
            poll_counter_next = poll_counter_next + 16'd1;
            if (poll_counter_next >= ack_poll_limit) begin
              ack_seen_next    = 1'b0;
              ack_timeout_next = 1'b1;
              advance          = 1'b1;
            end
          end
        end else if ({1'b0, slot_counter_next} + 17'd1 >= {1'b0, slot_len}) begin
          // end of slot: shift out or sample in
          advance = 1'b1;
          if (active_cmd_next == OP_WRITE && slot_index_next < 5'(3 * BITS_PER_BYTE) &&
              bit_phase_next == 2'd2) begin
            shift_reg_next = {shift_reg_next[6:0], 1'b0};
          end
          if (active_cmd_next == OP_READ && slot_index_next[0]) begin
            shift_reg_next = {shift_reg_next[6:0], head.sda};
          end
        end else begin
          slot_counter_next = slot_counter_next + 16'd1;
        end

        // move to the next slot or finish
        if (advance) begin
          slot_index_next   = slot_index_next + 5'd1;
          bit_phase_next    = (bit_phase_next == 2'd2) ? 2'd0 : bit_phase_next + 2'd1;
          slot_counter_next = 16'd0;
          if (slot_index_next >= slot_count(active_cmd_next)) begin
            res_calc.done_res = 1'b1;
            running_next      = 1'b0;
            if (active_cmd_next == OP_READ) rd_byte_next = shift_reg_next;
            slot_index_next = 5'd0;
          end else begin
            lv = enter_slot(active_cmd_next, slot_index_next, bit_phase_next,
                            shift_reg_next[7], scl_level_next, sda_level_next);
            scl_level_next = lv.scl;
            sda_level_next = lv.sda;
            if (lv.poll_clr) poll_counter_next = 16'd0;
          end
        end
      end
      res_calc.read_data   = rd_byte_next;
      res_calc.ack_seen    = ack_seen_next;
      res_calc.ack_timeout = ack_timeout_next;
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      scl_level     <= 1'b1;
      sda_level     <= 1'b1;
      running       <= 1'b0;
      active_cmd    <= OP_START;
      slot_index    <= 5'd0;
      bit_phase     <= 2'd0;
      slot_counter  <= 16'd0;
      poll_counter  <= 16'd0;
      shift_reg     <= 8'd0;
      rd_byte       <= 8'd0;
      ack_seen_r    <= 1'b0;
      ack_timeout_r <= 1'b0;
    end else begin
      scl_level     <= scl_level_next;
      sda_level     <= sda_level_next;
      running       <= running_next;
      active_cmd    <= active_cmd_next;
      slot_index    <= slot_index_next;
      bit_phase     <= bit_phase_next;
      slot_counter  <= slot_counter_next;
      poll_counter  <= poll_counter_next;
      shift_reg     <= shift_reg_next;
      rd_byte       <= rd_byte_next;
      ack_seen_r    <= ack_seen_next;
      ack_timeout_r <= ack_timeout_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= pop | (res_valid & res_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res <= res_calc;
    end
  end

endmodule

[hdl/i2c_bit_level_master_core.sv]
// channel   direction  handshake                payload
// tick      in         tick_valid / tick_stall  tick  (cmd_valid, opcode, write_data, sda_in)
// res       out        res_valid / res_stall    res   (scl_out ... ack_timeout)
// config    in         psel/penable/pwrite      paddr[2] selects slot_ticks or ack_poll_limit
//
// one tick request is taken per cycle while tick_stall is low and gives one result; a taken
// tick is written into the queue, and when the back pops it, its result is registered in the
// output register and offered from there.
// synchronous reset clears the queue, the sequencer and the output register
// and loads slot_ticks 20, ack_poll_limit 60000; tick_stall is high the cycle after.
// a stalled result holds; ticks keep entering until QUEUE_DEPTH are waiting.
module i2c_bit_level_master_core #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               tick_valid,
  output logic               tick_stall,
  input  i2cbm_pkg::tick_t   tick,
  output logic               res_valid,
  input  logic               res_stall,
  output i2cbm_pkg::result_t res,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import i2cbm_pkg::*;

  logic [15:0] slot_ticks;
  logic [15:0] ack_poll_limit;
  logic        cfg_write;
  logic        push;
  logic        pop;
  entry_t      push_entry;
  entry_t      head;
  q_status_t   q_status;

  // configuration registers
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_ticks     <= SLOT_TICKS_RST;
      ack_poll_limit <= ACK_POLL_LIMIT_RST;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_SLOT_TICKS:     slot_ticks     <= pwdata[15:0];
        REG_ACK_POLL_LIMIT: ack_poll_limit <= pwdata[15:0];
        default:            slot_ticks     <= slot_ticks;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (paddr[2])
      REG_SLOT_TICKS:     prdata = {16'd0, slot_ticks};
      REG_ACK_POLL_LIMIT: prdata = {16'd0, ack_poll_limit};
      default:            prdata = 32'd0;
    endcase
  end

  // front: accept and classify ticks
  i2cbm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .tick_valid (tick_valid),
    .tick_stall (tick_stall),
    .tick       (tick),
    .q_status   (q_status),
    .push       (push),
    .push_entry (push_entry)
  );

  // queue between front and back
  i2cbm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  // back: bus sequencer and result register
  i2cbm_back u_back (
    .clk            (clk),
    .rst            (rst),
    .slot_ticks     (slot_ticks),
    .ack_poll_limit (ack_poll_limit),
    .q_status       (q_status),
    .head           (head),
    .pop            (pop),
    .res_valid      (res_valid),
    .res_stall      (res_stall),
    .res            (res)
  );

endmodule

[bench/i2c_bit_level_master_core_tb.sv]
module i2c_bit_level_master_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cbm_pkg::*;

  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES = 200;

  typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;

  // one directed step: a single tick, a whole command, or a register write
  typedef struct packed {
    row_kind_t  kind;
    logic       cmd_valid;
    logic [2:0] op;
    logic [15:0] data;
    logic       reg_idx;
    logic [6:0] sda_pct;
    logic [6:0] noise_pct;
    logic       has_exp;
    result_t    want;
  } dir_row_t;

  localparam result_t NO_RES = '0;

  localparam dir_row_t DIR_ROWS [17] = '{
    // idle tick right after reset: lines released, no status
    '{ROW_TICK, 1'b0, OP_START, 16'h0000, REG_SLOT_TICKS, 7'd100, 7'd0, 1'b1,
      '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0}},
    // start at the reset slot length
    '{ROW_TICK, 1'b1, OP_START, 16'h0000, REG_SLOT_TICKS, 7'd50, 7'd0, 1'b0, NO_RES},
    '{ROW_CFG, 1'b0, OP_START, 16'd1, REG_SLOT_TICKS, 7'd0, 7'd0, 1'b0, NO_RES},
    '{ROW_CFG, 1'b0, OP_START, 16'd3, REG_ACK_POLL_LIMIT, 7'd0, 7'd0, 1'b0, NO_RES},
    '{ROW_TICK, 1'b1, OP_WRITE, 16'h00ff, REG_SLOT_TICKS, 7'd100, 7'd0, 1'b0, NO_RES},
    // acknowledge seen at once
    '{ROW_TICK, 1'b1, OP_WAIT_ACK, 16'h0000, REG_SLOT_TICKS, 7'd0, 7'd0, 1'b0, NO_RES},
    '{ROW_TICK, 1'b1, OP_WRITE, 16'h0000, REG_SLOT_TICKS, 7'd100, 7'd0, 1'b0, NO_RES},
    // acknowledge never comes, poll limit reached
    '{ROW_TICK, 1'b1, OP_WAIT_ACK, 16'h0000, REG_SLOT_TICKS, 7'd100, 7'd0, 1'b0, NO_RES},
    // commands offered on every busy tick must be ignored
    '{ROW_TICK, 1'b1, OP_WRITE, 16'h00a5, REG_SLOT_TICKS, 7'd50, 7'd100, 1'b0, NO_RES},
    '{ROW_TICK, 1'b1, OP_READ, 16'h0000, REG_SLOT_TICKS, 7'd100, 7'd0, 1'b0, NO_RES},
    '{ROW_TICK, 1'b1, OP_ACK, 16'h0000, REG_SLOT_TICKS, 7'd50, 7'd0, 1'b0, NO_RES},
    '{ROW_TICK, 1'b1, OP_READ, 16'h0000, REG_SLOT_TICKS, 7'd0, 7'd0, 1'b0, NO_RES},
    '{ROW_TICK, 1'b1, OP_NACK, 16'h0000, REG_SLOT_TICKS, 7'd50, 7'd0, 1'b0, NO_RES},
    '{ROW_TICK, 1'b1, OP_STOP, 16'h0000, REG_SLOT_TICKS, 7'd50, 7'd0, 1'b0, NO_RES},
    // unused opcode while idle: levels held after stop, last read 0, last ack timed out
    '{ROW_TICK, 1'b1, OP_UNUSED, 16'h00ff, REG_SLOT_TICKS, 7'd100, 7'd0, 1'b1,
      '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b1}},
    '{ROW_TICK, 1'b1, OP_WAIT_ACK, 16'h0000, REG_SLOT_TICKS, 7'd90, 7'd0, 1'b0, NO_RES},
    '{ROW_TICK, 1'b1, OP_START, 16'h0000, REG_SLOT_TICKS, 7'd50, 7'd0, 1'b0, NO_RES}
  };

  logic        clk;
  logic        rst = 1'b1;
  logic        tick_valid = 1'b0;
  logic        tick_stall;
  tick_t       tick = '0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  result_t     res;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  i2c_bit_level_master_core u_dut (
    .clk        (clk),
    .rst        (rst),
    .tick_valid (tick_valid),
    .tick_stall (tick_stall),
    .tick       (tick),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res        (res),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // bus levels and status expected for each accepted tick, oldest first
  result_t bus_state_q [$];
  bit      failed = 1'b0;
  int      busy_ticks = 0;
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;
  bit      press_en = 1'b0;
  bit      hold_done = 1'b0;
  int      hold_left = 0;

  // sequencer shadow: configuration and state
  logic [15:0] slot_len_cfg;
  logic [15:0] poll_limit_cfg;
  logic        seq_scl, seq_sda, seq_run;
  opcode_t     seq_cmd;
  int unsigned seq_slot;
  logic [15:0] seq_cnt, seq_poll;
  logic [7:0]  seq_shift, last_read;
  logic        last_ack_seen, last_ack_tmo;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #30ms;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic int unsigned slots_for(opcode_t c);
    case (c)
      OP_START: return 3;
      OP_WRITE: return 3 * BITS_PER_BYTE + 1;
      OP_READ:  return 2 * BITS_PER_BYTE;
      default:  return 4;
    endcase
  endfunction

  // line levels taken on the first tick of a slot
  function automatic void load_slot_levels();
    case (seq_cmd)
      OP_START: begin
        seq_scl = 1'b1;
        seq_sda = (seq_slot == 0);
      end
      OP_STOP: begin
        if (seq_slot == 0) seq_scl = 1'b0;
        else if (seq_slot == 1) seq_sda = 1'b0;
        else if (seq_slot == 2) seq_scl = 1'b1;
        else seq_sda = 1'b1;
      end
      OP_WAIT_ACK: begin
        if (seq_slot == 0) begin
          seq_scl = 1'b0;
          seq_sda = 1'b1;
        end else if (seq_slot == 1) begin
          seq_scl = 1'b1;
          seq_poll = '0;
        end else if (seq_slot == 3) begin
          seq_scl = 1'b0;
        end
      end
      OP_WRITE: begin
        if (seq_slot >= 3 * BITS_PER_BYTE) seq_scl = 1'b0;
        else if (seq_slot % 3 == 0) seq_scl = 1'b0;
        else if (seq_slot % 3 == 1) seq_sda = seq_shift[7];
        else seq_scl = 1'b1;
      end
      OP_READ: begin
        seq_sda = 1'b1;
        seq_scl = (seq_slot % 2 == 1);
      end
      default: begin
        if (seq_slot == 0) seq_scl = 1'b0;
        else if (seq_slot == 1) seq_sda = (seq_cmd == OP_NACK);
        else if (seq_slot == 2) seq_scl = 1'b1;
        else seq_scl = 1'b0;
      end
    endcase
  endfunction

  function automatic void reset_sequencer();
    slot_len_cfg = SLOT_TICKS_RST;
    poll_limit_cfg = ACK_POLL_LIMIT_RST;
    seq_scl = 1'b1;
    seq_sda = 1'b1;
    seq_run = 1'b0;
    seq_cmd = OP_START;
    seq_slot = 0;
    seq_cnt = '0;
    seq_poll = '0;
    seq_shift = '0;
    last_read = '0;
    last_ack_seen = 1'b0;
    last_ack_tmo = 1'b0;
  endfunction

  // advance the shadow sequencer by one tick and give that tick's outputs
  function automatic result_t sequencer_step(tick_t t);
    result_t r;
    int unsigned len;
    bit adv;
    r = '0;
    adv = 1'b0;
    len = (slot_len_cfg == 0) ? 1 : slot_len_cfg;
    if (!seq_run && t.cmd_valid && t.opcode != OP_UNUSED) begin
      seq_run = 1'b1;
      seq_cmd = opcode_t'(t.opcode);
      seq_slot = 0;
      seq_cnt = '0;
      seq_poll = '0;
      seq_shift = (seq_cmd == OP_WRITE) ? t.write_data : 8'h00;
      load_slot_levels();
    end
    r.scl_out = seq_scl;
    r.sda_out = seq_sda;
    if (seq_run) begin
      r.busy_res = 1'b1;
      if (seq_cmd == OP_WAIT_ACK && seq_slot == 1) begin
        // poll phase: low data ends it as acknowledged
        if (!t.sda_in) begin
          last_ack_seen = 1'b1;
          last_ack_tmo = 1'b0;
          adv = 1'b1;
        end else begin
          seq_poll = seq_poll + 16'd1;
          if (seq_poll >= poll_limit_cfg) begin
            last_ack_seen = 1'b0;
            last_ack_tmo = 1'b1;
            adv = 1'b1;
          end
        end
      end else if (seq_cnt + 1 >= len) begin
        adv = 1'b1;
        if (seq_cmd == OP_WRITE && seq_slot < 3 * BITS_PER_BYTE && seq_slot % 3 == 2)
          seq_shift = seq_shift << 1;
        if (seq_cmd == OP_READ && seq_slot % 2 == 1)
          seq_shift = {seq_shift[6:0], t.sda_in};
      end else begin
        seq_cnt = seq_cnt + 16'd1;
      end
      if (adv) begin
        seq_slot++;
        seq_cnt = '0;
        if (seq_slot >= slots_for(seq_cmd)) begin
          r.done_res = 1'b1;
          seq_run = 1'b0;
          if (seq_cmd == OP_READ) last_read = seq_shift;
          seq_slot = 0;
        end else begin
          load_slot_levels();
        end
      end
    end
    r.read_data = last_read;
    r.ack_seen = last_ack_seen;
    r.ack_timeout = last_ack_tmo;
    return r;
  endfunction

  function automatic logic sda_draw(int pct);
    return ($urandom_range(0, 99) < pct);
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 50;
      2: return 90;
      default: return 100;
    endcase
  endfunction

  // offer one tick request and record what it should produce
  task automatic send_tick(input logic v, input logic [2:0] op, input logic [7:0] wd,
                           input logic sda, input logic typed, input result_t typed_res);
    tick_t t;
    result_t r;
    t = '{v, op, wd, sda};
    while ($urandom_range(0, 99) < send_idle_pct) begin
      tick_valid <= 1'b0;
      @(posedge clk);
    end
    tick_valid <= 1'b1;
    tick <= t;
    do @(posedge clk); while (tick_stall);
    r = sequencer_step(t);
    bus_state_q.push_back(typed ? typed_res : r);
    if (r.busy_res) busy_ticks++;
  endtask

  // issue a command on an idle sequencer and tick it to completion
  task automatic run_command(input logic [2:0] op, input logic [7:0] wd, input int sda_pct,
                             input int noise_pct);
    send_tick(1'b1, op, wd, sda_draw(sda_pct), 1'b0, NO_RES);
    while (seq_run)
      send_tick($urandom_range(0, 99) < noise_pct, 3'($urandom_range(0, 7)), 8'($urandom),
                sda_draw(sda_pct), 1'b0, NO_RES);
  endtask

  task automatic idle_gap();
    repeat ($urandom_range(0, 3))
      send_tick($urandom_range(0, 1) ? 1'b0 : 1'b1, OP_UNUSED, 8'($urandom),
                1'($urandom_range(0, 1)), 1'b0, NO_RES);
  endtask

  // mostly well-formed transfers, some loose commands
  task automatic run_transaction();
    int n;
    int noise;
    logic [7:0] addr;
    noise = ($urandom_range(0, 3) == 0) ? 10 : 0;
    if ($urandom_range(0, 99) < 85) begin
      addr = 8'($urandom);
      n = $urandom_range(1, 3);
      run_command(OP_START, 8'($urandom), pick_pct(), noise);
      idle_gap();
      run_command(OP_WRITE, addr, pick_pct(), noise);
      idle_gap();
      run_command(OP_WAIT_ACK, 8'($urandom), pick_pct(), noise);
      idle_gap();
      for (int k = 0; k < n; k++) begin
        if (addr[0]) begin
          run_command(OP_READ, 8'($urandom), pick_pct(), noise);
          run_command((k == n - 1) ? OP_NACK : OP_ACK, 8'($urandom), pick_pct(), noise);
        end else begin
          run_command(OP_WRITE, 8'($urandom), pick_pct(), noise);
          run_command(OP_WAIT_ACK, 8'($urandom), pick_pct(), noise);
        end
        idle_gap();
      end
      run_command(OP_STOP, 8'($urandom), pick_pct(), noise);
    end else begin
      n = $urandom_range(1, 4);
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(0, 4) == 0)
          send_tick(1'b1, OP_UNUSED, 8'($urandom), 1'($urandom_range(0, 1)), 1'b0, NO_RES);
        else
          run_command(3'($urandom_range(OP_START, OP_NACK)), 8'($urandom), pick_pct(),
                      noise);
      end
    end
    idle_gap();
  endtask

  // let every outstanding result come back before touching registers
  task automatic wait_quiet();
    int waited;
    waited = 0;
    tick_valid <= 1'b0;
    while (bus_state_q.size() != 0 && waited < 10000) begin
      @(posedge clk);
      waited++;
    end
    if (bus_state_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, bus_state_q.size());
      failed = 1'b1;
      bus_state_q.delete();
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic idx, input logic [15:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'h0000, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_SLOT_TICKS:     slot_len_cfg = val;
      REG_ACK_POLL_LIMIT: poll_limit_cfg = val;
      default: ;
    endcase
  endtask

  task automatic run_phase(input logic [15:0] slot_len, input logic [15:0] poll_limit,
                           input int s_pct, input int r_pct, input bit press, input int goal);
    wait_quiet();
    cfg_write(REG_SLOT_TICKS, slot_len);
    cfg_write(REG_ACK_POLL_LIMIT, poll_limit);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    press_en = press;
    busy_ticks = 0;
    while (busy_ticks < goal) run_transaction();
  endtask

  // result side: random stalls plus one long hold-off under pressure
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        res_stall <= 1'b1;
        hold_left--;
      end else if (press_en && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        res_stall <= 1'b1;
      end else begin
        res_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      failed = 1'b1;
    end
  endtask

  // compare each returned result with the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (!rst && res_valid && !res_stall) begin
      if (bus_state_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, res);
        failed = 1'b1;
      end else begin
        want = bus_state_q.pop_front();
        check_field("scl_out", 8'(want.scl_out), 8'(res.scl_out));
        check_field("sda_out", 8'(want.sda_out), 8'(res.sda_out));
        check_field("busy_res", 8'(want.busy_res), 8'(res.busy_res));
        check_field("done_res", 8'(want.done_res), 8'(res.done_res));
        check_field("read_data", want.read_data, res.read_data);
        check_field("ack_seen", 8'(want.ack_seen), 8'(res.ack_seen));
        check_field("ack_timeout", 8'(want.ack_timeout), 8'(res.ack_timeout));
      end
    end
  end

  initial begin
    dir_row_t row;
    reset_sequencer();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed steps
    for (int i = 0; i < 17; i++) begin
      row = DIR_ROWS[i];
      if (row.kind == ROW_CFG) begin
        wait_quiet();
        cfg_write(row.reg_idx, row.data);
      end else if (row.cmd_valid && row.op != OP_UNUSED && !row.has_exp) begin
        run_command(row.op, row.data[7:0], int'(row.sda_pct), int'(row.noise_pct));
      end else begin
        send_tick(row.cmd_valid, row.op, row.data[7:0], sda_draw(int'(row.sda_pct)),
                  row.has_exp, row.want);
      end
    end

    // random transfers under three idling patterns
    run_phase(16'd0, 16'd0, 30, 58, 1'b0, 330);
    run_phase(16'd2, 16'd5, 58, 30, 1'b0, 330);
    run_phase(16'd3, 16'd2, 0, 0, 1'b1, 330);

    // register extremes: longest slot cut short by a shorter one
    run_phase(16'hffff, 16'hffff, 0, 0, 1'b0, 0);
    repeat (8) send_tick(1'b1, OP_START, 8'h00, 1'b1, 1'b0, NO_RES);
    run_phase(16'd1, 16'hffff, 0, 0, 1'b0, 0);
    while (seq_run) send_tick(1'b0, OP_START, 8'h00, 1'b1, 1'b0, NO_RES);

    // longest poll limit, then lowered below the count already reached
    send_tick(1'b1, OP_WAIT_ACK, 8'h00, 1'b1, 1'b0, NO_RES);
    repeat (40) send_tick(1'b0, OP_START, 8'h00, 1'b1, 1'b0, NO_RES);
    run_phase(16'd1, 16'd1, 0, 0, 1'b0, 0);
    while (seq_run) send_tick(1'b0, OP_START, 8'h00, 1'b1, 1'b0, NO_RES);
    run_command(OP_STOP, 8'h00, 50, 0);

    wait_quiet();
    if (!failed) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/i2cbm_pkg.sv
hdl/i2cbm_front.sv
hdl/i2cbm_queue.sv
hdl/i2cbm_back.sv
hdl/i2c_bit_level_master_core.sv
bench/i2c_bit_level_master_core_tb.sv
